[rtl/mwg_pkg.sv]
// Shared types, codes and waveform tables for the multi-waveform generator.
package mwg_pkg;

    localparam int MODE_W  = 3;
    localparam int TICKS_W = 16;
    localparam int PHASE_W = 9;
    localparam int DAC_W   = 8;
    localparam int ADDR_W  = 1;

    localparam logic [ADDR_W-1:0] REG_WAVE_MODE      = 1'd0;
    localparam logic [ADDR_W-1:0] REG_TICKS_PER_STEP = 1'd1;

    localparam logic [MODE_W-1:0] MODE_SINE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AM       = 3'd4;

    localparam logic [PHASE_W-1:0] SINE_LEN   = 9'd12;
    localparam logic [PHASE_W-1:0] SQUARE_LEN = 9'd2;
    localparam logic [PHASE_W-1:0] TRI_LEN    = 9'd510;
    localparam logic [PHASE_W-1:0] SAW_LEN    = 9'd14;
    localparam logic [PHASE_W-1:0] AM_LEN     = 9'd51;
    localparam logic [PHASE_W-1:0] AM_PERIOD  = 9'd102;
    localparam logic [PHASE_W-1:0] TRI_PEAK   = 9'd254;
    localparam logic [PHASE_W-1:0] SAW_TOP    = 9'd12;
    localparam logic [DAC_W-1:0]   SAW_MAX    = 8'd240;
    localparam logic [DAC_W-1:0]   DAC_MAX    = 8'd255;

    typedef struct packed {
        logic [DAC_W-1:0] dac_code;
        logic             step_taken;
    } mwg_result_t;

    function automatic logic [PHASE_W-1:0] wave_period(input logic [MODE_W-1:0] mode);
        logic [PHASE_W-1:0] p;
        unique case (mode)
            MODE_SINE:     p = SINE_LEN;
            MODE_SQUARE:   p = SQUARE_LEN;
            MODE_TRIANGLE: p = TRI_LEN;
            MODE_SAWTOOTH: p = SAW_LEN;
            MODE_AM:       p = AM_PERIOD;
            default:       p = 9'd1;
        endcase
        return p;
    endfunction

    function automatic logic [DAC_W-1:0] sine_lut(input logic [3:0] idx);
        logic [DAC_W-1:0] v;
        unique case (idx)
            4'd0:    v = 8'd128;
            4'd1:    v = 8'd192;
            4'd2:    v = 8'd238;
            4'd3:    v = 8'd255;
            4'd4:    v = 8'd238;
            4'd5:    v = 8'd192;
            4'd6:    v = 8'd128;
            4'd7:    v = 8'd64;
            4'd8:    v = 8'd17;
            4'd9:    v = 8'd0;
            4'd10:   v = 8'd17;
            4'd11:   v = 8'd64;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [DAC_W-1:0] am_lut(input logic [5:0] idx);
        logic [DAC_W-1:0] v;
        unique case (idx)
            6'd0:  v = 8'd255; 6'd1:  v = 8'd230; 6'd2:  v = 8'd166; 6'd3:  v = 8'd88;
            6'd4:  v = 8'd26;  6'd5:  v = 8'd0;   6'd6:  v = 8'd27;  6'd7:  v = 8'd90;
            6'd8:  v = 8'd165; 6'd9:  v = 8'd224; 6'd10: v = 8'd245; 6'd11: v = 8'd221;
            6'd12: v = 8'd163; 6'd13: v = 8'd93;  6'd14: v = 8'd40;  6'd15: v = 8'd22;
            6'd16: v = 8'd44;  6'd17: v = 8'd97;  6'd18: v = 8'd158; 6'd19: v = 8'd204;
            6'd20: v = 8'd219; 6'd21: v = 8'd199; 6'd22: v = 8'd154; 6'd23: v = 8'd102;
            6'd24: v = 8'd64;  6'd25: v = 8'd53;  6'd26: v = 8'd69;  6'd27: v = 8'd106;
            6'd28: v = 8'd148; 6'd29: v = 8'd178; 6'd30: v = 8'd186; 6'd31: v = 8'd173;
            6'd32: v = 8'd143; 6'd33: v = 8'd112; 6'd34: v = 8'd90;  6'd35: v = 8'd83;
            6'd36: v = 8'd91;  6'd37: v = 8'd115; 6'd38: v = 8'd139; 6'd39: v = 8'd155;
            6'd40: v = 8'd160; 6'd41: v = 8'd152; 6'd42: v = 8'd136; 6'd43: v = 8'd119;
            6'd44: v = 8'd106; 6'd45: v = 8'd102; 6'd46: v = 8'd108; 6'd47: v = 8'd120;
            6'd48: v = 8'd135; 6'd49: v = 8'd146; 6'd50: v = 8'd150;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/mwg_sample.sv]
// Maps waveform mode and phase to the converter code.
module mwg_sample (
    input  logic [mwg_pkg::MODE_W-1:0]  mode,
    input  logic [mwg_pkg::PHASE_W-1:0] phase,
    output logic [mwg_pkg::DAC_W-1:0]   dac_code
);
    import mwg_pkg::*;

    logic [PHASE_W-1:0] am_idx;
    logic [PHASE_W-1:0] tri_fall;
    logic [PHASE_W-1:0] saw_val;

    always_comb begin
        // backward half of the AM table mirrors the forward half
        am_idx   = (phase < AM_LEN) ? phase : AM_PERIOD - 9'd1 - phase;
        tri_fall = TRI_LEN - phase;
        saw_val  = (phase << 4) + (phase << 2);
        unique case (mode)
            MODE_SINE:     dac_code = sine_lut(phase[3:0]);
            MODE_SQUARE:   dac_code = phase[0] ? DAC_MAX : 8'd0;
            MODE_TRIANGLE: dac_code = (phase <= TRI_PEAK) ? phase[DAC_W-1:0]
                                                          : tri_fall[DAC_W-1:0];
            MODE_SAWTOOTH: dac_code = (phase > SAW_TOP) ? SAW_MAX : saw_val[DAC_W-1:0];
            MODE_AM:       dac_code = am_lut(am_idx[5:0]);
            default:       dac_code = 8'd0;
        endcase
    end

endmodule

[rtl/mwg_phase.sv]
// Hold counter and phase accumulator; forms one result per request.
module mwg_phase #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic                         restart,
    input  logic [mwg_pkg::MODE_W-1:0]   mode,
    input  logic [mwg_pkg::TICKS_W-1:0]  ticks_per_step,
    output mwg_pkg::mwg_result_t         result
);
    import mwg_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH + 1 > TICKS_W) ? COUNT_WIDTH + 1 : TICKS_W;

    logic [COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [PHASE_W-1:0]     phase_index_reg, phase_index_next;
    logic [PHASE_W-1:0]     period;
    logic [PHASE_W-1:0]     ph;
    logic [PHASE_W-1:0]     ph_inc;
    logic [TICKS_W-1:0]     hold;
    logic [CMP_W-1:0]       count_inc;
    logic                   step;
    logic [DAC_W-1:0]       code;

    mwg_sample u_sample (
        .mode     (mode),
        .phase    (ph),
        .dac_code (code)
    );

    always_comb begin
        period    = wave_period(mode);
        hold      = (ticks_per_step == '0) ? TICKS_W'(1) : ticks_per_step;
        ph        = (restart || phase_index_reg >= period) ? '0 : phase_index_reg;
        ph_inc    = ph + 9'd1;
        count_inc = CMP_W'(tick_count_reg) + CMP_W'(1);
        step      = !restart && ((count_inc >= CMP_W'(hold)) || (&tick_count_reg));

        if (restart) begin
            tick_count_next  = '0;
            phase_index_next = '0;
        end else if (step) begin
            tick_count_next  = '0;
            phase_index_next = (ph_inc >= period) ? '0 : ph_inc;
        end else begin
            tick_count_next  = count_inc[COUNT_WIDTH-1:0];
            phase_index_next = ph;
        end

        result.dac_code   = code;
        result.step_taken = step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            phase_index_reg <= '0;
        end else if (advance) begin
            tick_count_reg  <= tick_count_next;
            phase_index_reg <= phase_index_next;
        end
    end

endmodule

[rtl/mwg_out_buf.sv]
// Output register with skid stage for the result stream.
module mwg_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  mwg_pkg::mwg_result_t push_data,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mwg_pkg::mwg_result_t out_data
);
    import mwg_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    mwg_result_t out_data_reg;
    mwg_result_t skid_data_reg;

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

endmodule

[rtl/multi_waveform_generator.sv]
// Top level of the multi-waveform generator.
// Each accepted request is one timebase tick and yields exactly one result: the
// 8-bit converter code of the current phase and a flag set when the phase
// advanced on that tick. A request is taken every cycle while the skid stage is
// empty. Each result is registered in the output register, or, while the output
// is stalled, in the skid stage, which keeps input flowing for one extra request.
// Modes: 0 sine (12 samples), 1 square, 2 triangle (period 510), 3 sawtooth
// (period 14), 4 amplitude-modulated table played forward then backward (period
// 102); other mode codes output 0. Each sample is held for ticks_per_step ticks
// (0 acts as 1). Setting restart in a request returns phase and hold count to
// the start. Write configuration only while no request is outstanding.
module multi_waveform_generator #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [mwg_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [mwg_pkg::TICKS_W-1:0]  cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [0] restart
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata    // [7:0] dac_code, [8] step_taken
);
    import mwg_pkg::*;

    logic [MODE_W-1:0]  wave_mode_reg;
    logic [TICKS_W-1:0] ticks_per_step_reg;
    logic               accept;
    logic               can_push;
    mwg_result_t        result;
    mwg_result_t        out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_mode_reg      <= MODE_SINE;
            ticks_per_step_reg <= TICKS_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_WAVE_MODE:      wave_mode_reg      <= cfg_wdata[MODE_W-1:0];
                REG_TICKS_PER_STEP: ticks_per_step_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = can_push;
    assign accept   = s_tvalid && can_push;

    mwg_phase #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_phase (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (accept),
        .restart        (s_tdata[0]),
        .mode           (wave_mode_reg),
        .ticks_per_step (ticks_per_step_reg),
        .result         (result)
    );

    mwg_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (result),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {7'd0, out_data.step_taken, out_data.dac_code};

endmodule

[tb/mwg_sample_checker.sv]
// Watches the generator's ports, predicts each converter code and compares it.
module mwg_sample_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [mwg_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [mwg_pkg::TICKS_W-1:0]  cfg_wdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [0] restart
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [15:0]                  m_tdata,   // [7:0] dac_code, [8] step_taken
    output int                           results_seen,
    output int                           fail_count
);
    import mwg_pkg::*;

    localparam logic [12*8-1:0] SINE_BYTES = {
        8'd128, 8'd192, 8'd238, 8'd255, 8'd238, 8'd192,
        8'd128, 8'd64,  8'd17,  8'd0,   8'd17,  8'd64
    };

    localparam logic [51*8-1:0] AM_BYTES = {
        8'd255, 8'd230, 8'd166, 8'd88,  8'd26,  8'd0,   8'd27,  8'd90,
        8'd165, 8'd224, 8'd245, 8'd221, 8'd163, 8'd93,  8'd40,  8'd22,
        8'd44,  8'd97,  8'd158, 8'd204, 8'd219, 8'd199, 8'd154, 8'd102,
        8'd64,  8'd53,  8'd69,  8'd106, 8'd148, 8'd178, 8'd186, 8'd173,
        8'd143, 8'd112, 8'd90,  8'd83,  8'd91,  8'd115, 8'd139, 8'd155,
        8'd160, 8'd152, 8'd136, 8'd119, 8'd106, 8'd102, 8'd108, 8'd120,
        8'd135, 8'd146, 8'd150
    };

    logic [MODE_W-1:0]  cur_mode;
    logic [TICKS_W-1:0] cur_hold;
    logic [15:0]        hold_count;
    logic [PHASE_W-1:0] cur_phase;
    mwg_result_t        expected_codes[$];
    int                 bad_count;

    function automatic int period_of(input logic [MODE_W-1:0] mode);
        case (mode)
            MODE_SINE:     return 12;
            MODE_SQUARE:   return 2;
            MODE_TRIANGLE: return 510;
            MODE_SAWTOOTH: return 14;
            MODE_AM:       return 102;
            default:       return 1;
        endcase
    endfunction

    function automatic logic [DAC_W-1:0] level_at(input logic [MODE_W-1:0] mode, input int ph);
        case (mode)
            MODE_SINE:     return SINE_BYTES[(11 - (ph % 12)) * 8 +: 8];
            MODE_SQUARE:   return ph[0] ? 8'd255 : 8'd0;
            MODE_TRIANGLE: begin
                if (ph <= 254) return ph[7:0];
                if (ph < 510) return 8'(510 - ph);
                return 8'd0;
            end
            MODE_SAWTOOTH: return (ph > 12) ? 8'd240 : 8'(ph * 20);
            MODE_AM: begin
                if (ph < 51) return AM_BYTES[(50 - ph) * 8 +: 8];
                if (ph < 102) return AM_BYTES[(50 - (101 - ph)) * 8 +: 8];
                return 8'd0;
            end
            default:       return 8'd0;
        endcase
    endfunction

    // one timebase tick: returns the code driven now and updates phase and hold count
    function automatic mwg_result_t advance_tick(input logic restart);
        mwg_result_t r;
        int per;
        int ph;
        int eff_hold;
        per = period_of(cur_mode);
        if (restart) begin
            hold_count = '0;
            cur_phase = '0;
            r.dac_code = level_at(cur_mode, 0);
            r.step_taken = 1'b0;
            return r;
        end
        ph = (int'(cur_phase) < per) ? int'(cur_phase) : 0;
        r.dac_code = level_at(cur_mode, ph);
        eff_hold = (cur_hold == '0) ? 1 : int'(cur_hold);
        if (int'(hold_count) + 1 >= eff_hold || hold_count == '1) begin
            hold_count = '0;
            ph = ph + 1;
            if (ph >= per) ph = 0;
            r.step_taken = 1'b1;
        end else begin
            hold_count = hold_count + 1'b1;
            r.step_taken = 1'b0;
        end
        cur_phase = ph[PHASE_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        mwg_result_t got;
        mwg_result_t want;
        if (!aresetn) begin
            cur_mode = MODE_SINE;
            cur_hold = 16'd1;
            hold_count = '0;
            cur_phase = '0;
            expected_codes.delete();
            bad_count = 0;
            results_seen <= 0;
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_WAVE_MODE)
                    cur_mode = cfg_wdata[MODE_W-1:0];
                else if (cfg_addr == REG_TICKS_PER_STEP)
                    cur_hold = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_codes.push_back(advance_tick(s_tdata[0]));
            if (m_tvalid && m_tready) begin
                got.dac_code = m_tdata[7:0];
                got.step_taken = m_tdata[8];
                if (expected_codes.size() == 0) begin
                    if (bad_count < 10)
                        $display("result %0d with no request pending: dac %0d step %0d",
                                 results_seen, got.dac_code, got.step_taken);
                    bad_count++;
                end else begin
                    want = expected_codes.pop_front();
                    if (got.dac_code != want.dac_code || got.step_taken != want.step_taken) begin
                        if (bad_count < 10)
                            $display({"result %0d mismatch: expected dac %0d step %0d, ",
                                      "got dac %0d step %0d"},
                                     results_seen, want.dac_code, want.step_taken,
                                     got.dac_code, got.step_taken);
                        bad_count++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            fail_count <= bad_count + expected_codes.size();
        end
    end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for the multi-waveform generator regression.
module tb_top;
    import mwg_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          RANDOM_TICKS = 1925;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [ADDR_W-1:0]   cfg_addr;
    logic [TICKS_W-1:0]  cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;

    int          results_seen;
    int          fail_count;
    int          ticks_sent = 0;
    int          restarts_sent = 0;
    int          settings_run = 0;
    int unsigned cycle_count = 0;

    multi_waveform_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mwg_sample_checker sample_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .results_seen (results_seen),
        .fail_count   (fail_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("multi_waveform_generator regression: fail");
            $finish;
        end
    end

    // sink side: random stall before each result, with stretches of none
    initial begin : sink
        int  stall;
        bit  quick;
        m_tready = 1'b0;
        quick = 1'b0;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 63) == 0) quick = !quick;
            stall = quick ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    task automatic send_tick(input logic restart, input int gap);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
        if (restart) restarts_sent++;
    endtask

    // hold off until every request has its result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_seen != ticks_sent) @(posedge aclk);
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input logic [TICKS_W-1:0] hold,
                             input bit set_mode, input bit set_hold);
        if (set_mode) begin
            cfg_we <= 1'b1;
            cfg_addr <= REG_WAVE_MODE;
            cfg_wdata <= {{(TICKS_W-MODE_W){1'b0}}, mode};
            @(posedge aclk);
        end
        if (set_hold) begin
            cfg_we <= 1'b1;
            cfg_addr <= REG_TICKS_PER_STEP;
            cfg_wdata <= hold;
            @(posedge aclk);
        end
        if (set_mode || set_hold) cfg_we <= 1'b0;
    endtask

    task automatic run_setting(input logic [MODE_W-1:0] mode, input logic [TICKS_W-1:0] hold,
                               input bit set_mode, input bit set_hold, input int count,
                               input int restart_odds, input int pause_at);
        bit quick;
        logic restart;
        quick = ($urandom_range(0, 2) == 0);
        configure(mode, hold, set_mode, set_hold);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at && i != 0) drain();
            restart = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
            send_tick(restart, quick ? 0 : $urandom_range(0, 14));
        end
        drain();
        settings_run++;
    endtask

    initial begin : stimulus
        logic [MODE_W-1:0]  mode;
        logic [TICKS_W-1:0] hold;
        int                 count;
        int                 target;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, restart in the middle
        send_tick(1'b0, 0);
        send_tick(1'b0, 3);
        send_tick(1'b1, 0);
        send_tick(1'b0, 1);
        drain();
        // one short run per mode and for two unused mode codes, zero and full-scale holds among them
        for (int i = 0; i < 7; i++) begin
            case (i)
                0: configure(MODE_SINE, 16'd0, 1'b1, 1'b1);
                1: configure(MODE_SQUARE, 16'd1, 1'b1, 1'b1);
                2: configure(MODE_TRIANGLE, 16'hFFFF, 1'b1, 1'b1);
                3: configure(MODE_SAWTOOTH, 16'd2, 1'b1, 1'b1);
                4: configure(MODE_AM, 16'd1, 1'b1, 1'b1);
                5: configure(MODE_UNUSED_LO, 16'd3, 1'b1, 1'b1);
                default: configure(MODE_UNUSED_HI, 16'd1, 1'b1, 1'b1);
            endcase
            send_tick(1'b0, 0);
            send_tick(i[0], 0);
            send_tick(1'b0, 2);
            drain();
            settings_run++;
        end

        target = ticks_sent + RANDOM_TICKS;
        // full triangle period, then sawtooth entered with the phase past its period
        run_setting(MODE_TRIANGLE, 16'd1, 1'b1, 1'b1, 560, 0, 300);
        run_setting(MODE_SAWTOOTH, 16'd1, 1'b1, 1'b0, 40, 0, -1);
        while (ticks_sent < target) begin
            if ($urandom_range(0, 9) < 8)
                mode = MODE_W'($urandom_range(MODE_SINE, MODE_AM));
            else
                mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            case ($urandom_range(0, 9))
                0:       hold = 16'd0;
                1:       hold = 16'hFFFF;
                2:       hold = TICKS_W'($urandom_range(0, 65535));
                3, 4:    hold = TICKS_W'($urandom_range(5, 60));
                default: hold = TICKS_W'($urandom_range(1, 4));
            endcase
            count = $urandom_range(30, 250);
            if (count > target - ticks_sent) count = target - ticks_sent;
            run_setting(mode, hold, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, count,
                        ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(8, 64),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(1, count - 1) : -1);
        end

        repeat (4) @(posedge aclk);
        $display("covered %0d ticks (%0d restarts) over %0d register settings",
                 ticks_sent, restarts_sent, settings_run);
        $display("mode codes 0 to 7, holds 0 to 65535, random source gaps and sink stalls");
        if (fail_count == 0)
            $display("multi_waveform_generator regression: pass");
        else
            $display("multi_waveform_generator regression: fail");
        $finish;
    end

endmodule
